// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, off while reset is asserted.
`define VLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds through reset.
`define VLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/vlr_pkg.sv
// Shared constants and beat types for the vector length rescale block.
package vlr_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int GUARD_BITS = 8;
  localparam int CW         = 16;                    // component width
  localparam int TW         = 16;                    // target length width
  localparam int NL         = 3;                     // vector lanes
  localparam int SW         = 2 * CW;                // squared length width
  localparam int PW         = CW + TW;               // |c| * target width
  localparam int RADW       = SW + 2 * GUARD_BITS;   // square root radicand width
  localparam int MAGW       = RADW / 2;              // magnitude width
  localparam int REMW       = MAGW + 1;              // root remainder width
  localparam int ROOT_STEPS = RADW / 2;
  localparam int NUMW       = PW + GUARD_BITS;       // dividend width
  localparam int QW         = NUMW - MAGW;           // quotient bits resolved

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MODE   = 2'd1;
  localparam logic [TW-1:0] TARGET_RESET = TW'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } vlr_in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 was_scaled;
    logic                 zero_length;
    logic                 saturated;
  } vlr_out_t;

  // Per-item bookkeeping that rides along the whole pipeline.
  typedef struct packed {
    logic [NL-1:0][CW-1:0] comp;
    logic [NL-1:0]         neg;
    logic                  scaled;
    logic                  zero;
  } vlr_meta_t;

  // Front end to square root.
  typedef struct packed {
    vlr_meta_t             meta;
    logic [NL-1:0][PW-1:0] prod;
    logic [SW-1:0]         sum;
  } vlr_item_t;

  // Square root to divider.
  typedef struct packed {
    vlr_meta_t             meta;
    logic [NL-1:0][PW-1:0] prod;
    logic [MAGW-1:0]       mag;
  } vlr_root_t;

  // Divider stage contents.
  typedef struct packed {
    vlr_meta_t               meta;
    logic [MAGW-1:0]         mag;
    logic [NL-1:0][NUMW-1:0] num;
    logic [NL-1:0][MAGW-1:0] rem;
    logic [NL-1:0][QW-1:0]   quo;
    logic [NL-1:0]           ovf;
  } vlr_div_t;

endpackage

// File: rtl/vlr_front.sv
// Front end: absolute values, squares, squared length, decision and products.
module vlr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  vlr_pkg::vlr_in_t     up_data,
  input  logic [vlr_pkg::TW-1:0] target,
  input  logic                 mode,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output vlr_pkg::vlr_item_t   dn_item
);
  import vlr_pkg::*;

  logic                  a_v_r;
  logic [NL-1:0][CW-1:0] a_comp_r;
  logic [NL-1:0]         a_neg_r;
  logic [NL-1:0][CW-1:0] a_abs_r;
  logic [NL-1:0][SW-1:0] a_sq_r;
  logic [SW-1:0]         a_tt_r;
  logic                  b_v_r;
  vlr_item_t             b_item_r;

  logic                  rdy_a, rdy_b;
  logic [NL-1:0][CW-1:0] comp_in;
  logic [NL-1:0][CW-1:0] abs_nxt;
  logic [SW-1:0]         sum;

  assign rdy_b    = !b_v_r || dn_ready;
  assign rdy_a    = !a_v_r || rdy_b;
  assign up_ready = rdy_a;

  // Magnitudes of the incoming components.
  always_comb begin
    comp_in = {up_data.in_z, up_data.in_y, up_data.in_x};
    for (int i = 0; i < NL; i++) begin
      abs_nxt[i] = comp_in[i][CW-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
    end
  end

  // Stage A: squares of the components and of the target.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= up_valid;
    end
    if (rdy_a) begin
      a_comp_r <= comp_in;
      a_abs_r  <= abs_nxt;
      a_tt_r   <= target * target;
      for (int i = 0; i < NL; i++) begin
        a_neg_r[i] <= comp_in[i][CW-1];
        a_sq_r[i]  <= abs_nxt[i] * abs_nxt[i];
      end
    end
  end

  assign sum = a_sq_r[0] + a_sq_r[1] + a_sq_r[2];

  // Stage B: squared length, scale decision and |c| * target products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (rdy_b) begin
      b_v_r <= a_v_r;
    end
    if (rdy_b) begin
      b_item_r.sum         <= sum;
      b_item_r.meta.comp   <= a_comp_r;
      b_item_r.meta.neg    <= a_neg_r;
      b_item_r.meta.scaled <= mode ? (sum != '0) : (sum > a_tt_r);
      b_item_r.meta.zero   <= mode && (sum == '0);
      for (int i = 0; i < NL; i++) begin
        b_item_r.prod[i] <= a_abs_r[i] * target;
      end
    end
  end

  assign dn_valid = b_v_r;
  assign dn_item  = b_item_r;

endmodule

// File: rtl/vlr_sqrt.sv
// Square root pipeline: one root bit per stage of floor(sqrt(S * 2^16)).
module vlr_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  vlr_pkg::vlr_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output vlr_pkg::vlr_root_t dn_root
);
  import vlr_pkg::*;

  logic [ROOT_STEPS:0] pv;
  logic [ROOT_STEPS:0] rdy;
  vlr_item_t           pitem [ROOT_STEPS+1];
  logic [REMW-1:0]     prem  [ROOT_STEPS+1];
  logic [MAGW-1:0]     proot [ROOT_STEPS+1];

  assign pv[0]           = up_valid;
  assign pitem[0]        = up_item;
  assign prem[0]         = '0;
  assign proot[0]        = '0;
  assign rdy[ROOT_STEPS] = dn_ready;
  assign up_ready        = rdy[0];

  for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
    localparam int P = ROOT_STEPS - 1 - s;
    logic            v_r;
    vlr_item_t       item_r;
    logic [REMW-1:0] rem_r;
    logic [MAGW-1:0] root_r;
    logic [RADW-1:0] rad;
    logic [REMW+1:0] sh, trial, diff;
    logic            ge;

    // Bring in the next two radicand bits and try the next root bit.
    assign rad   = {pitem[s].sum, {(2 * GUARD_BITS){1'b0}}};
    assign sh    = {prem[s], rad[2*P+1 -: 2]};
    assign trial = {1'b0, proot[s], 2'b01};
    assign diff  = sh - trial;
    assign ge    = (sh >= trial);
    assign rdy[s] = !v_r || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[s]) begin
        v_r <= pv[s];
      end
      if (rdy[s]) begin
        item_r <= pitem[s];
        rem_r  <= ge ? diff[REMW-1:0] : sh[REMW-1:0];
        root_r <= {proot[s][MAGW-2:0], ge};
      end
    end

    assign pv[s+1]    = v_r;
    assign pitem[s+1] = item_r;
    assign prem[s+1]  = rem_r;
    assign proot[s+1] = root_r;
  end

  assign dn_valid     = pv[ROOT_STEPS];
  assign dn_root.meta = pitem[ROOT_STEPS].meta;
  assign dn_root.prod = pitem[ROOT_STEPS].prod;
  assign dn_root.mag  = proot[ROOT_STEPS];

endmodule

// File: rtl/vlr_div.sv
// Divider pipeline: rounded c * target / |v| per lane, then saturation and select.
module vlr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  vlr_pkg::vlr_root_t up_root,
  output logic               dn_valid,
  input  logic               dn_ready,
  output vlr_pkg::vlr_out_t  dn_data
);
  import vlr_pkg::*;

  logic [QW+1:0] rdy;
  logic [QW:0]   pv;
  vlr_div_t      pd [QW+1];

  logic          p_v_r;
  vlr_div_t      p_r;
  logic          o_v_r;
  vlr_out_t      o_r;

  logic [NL-1:0][NUMW-1:0] num;
  logic [NL-1:0][CW-1:0]   res;
  logic [NL-1:0]           lane_sat;
  vlr_div_t                fin;
  logic                    bad;

  assign rdy[QW+1] = !o_v_r || dn_ready;
  assign rdy[0]    = !p_v_r || rdy[1];
  assign up_ready  = rdy[0];

  // Rounded dividend: (|c| * target) << guard bits, plus half the divisor.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      num[i] = {up_root.prod[i], {GUARD_BITS{1'b0}}} + NUMW'(up_root.mag >> 1);
    end
  end

  // Prep stage: a quotient of 2^QW or more is flagged as overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (rdy[0]) begin
      p_v_r <= up_valid;
    end
    if (rdy[0]) begin
      p_r.meta <= up_root.meta;
      p_r.mag  <= up_root.mag;
      p_r.num  <= num;
      p_r.quo  <= '0;
      for (int i = 0; i < NL; i++) begin
        p_r.rem[i] <= num[i][NUMW-1 -: MAGW];
        p_r.ovf[i] <= (num[i][NUMW-1 -: MAGW] >= up_root.mag);
      end
    end
  end

  assign pv[0] = p_v_r;
  assign pd[0] = p_r;

  // Restoring division, one quotient bit per stage on all lanes.
  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = QW - 1 - j;
    logic     v_r;
    vlr_div_t d_r;
    vlr_div_t d_nxt;

    always_comb begin
      logic [MAGW:0] r2;
      logic [MAGW:0] df;
      logic          ge;
      d_nxt = pd[j];
      for (int i = 0; i < NL; i++) begin
        r2 = {pd[j].rem[i], pd[j].num[i][B]};
        df = r2 - {1'b0, pd[j].mag};
        ge = (r2 >= {1'b0, pd[j].mag});
        d_nxt.rem[i] = ge ? df[MAGW-1:0] : r2[MAGW-1:0];
        d_nxt.quo[i] = {pd[j].quo[i][QW-2:0], ge};
      end
    end

    assign rdy[j+1] = !v_r || rdy[j+2];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[j+1]) begin
        v_r <= pv[j];
      end
      if (rdy[j+1]) begin
        d_r <= d_nxt;
      end
    end

    assign pv[j+1] = v_r;
    assign pd[j+1] = d_r;
  end

  assign fin = pd[QW];

  // Sign, saturation and choice between scaled, zeroed and passed components.
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < NL; i++) begin
      if (fin.meta.neg[i]) begin
        bad = fin.ovf[i] || (fin.quo[i][QW-1] && (fin.quo[i][QW-2:0] != '0));
        res[i] = bad ? {1'b1, {(CW-1){1'b0}}} : CW'(~fin.quo[i] + 1'b1);
      end else begin
        bad = fin.ovf[i] || fin.quo[i][QW-1];
        res[i] = bad ? {1'b0, {(CW-1){1'b1}}} : CW'(fin.quo[i]);
      end
      lane_sat[i] = bad;
      if (!fin.meta.scaled) begin
        res[i] = fin.meta.zero ? '0 : fin.meta.comp[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (rdy[QW+1]) begin
      o_v_r <= pv[QW];
    end
    if (rdy[QW+1]) begin
      o_r.out_x       <= res[0];
      o_r.out_y       <= res[1];
      o_r.out_z       <= res[2];
      o_r.was_scaled  <= fin.meta.scaled;
      o_r.zero_length <= fin.meta.zero;
      o_r.saturated   <= fin.meta.scaled && (lane_sat != '0);
    end
  end

  assign dn_valid = o_v_r;
  assign dn_data  = o_r;

endmodule

// File: rtl/vector_length_rescale_core.sv
// Top level of the vector length clamp and set pipeline.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_ready   | vlr_in_t  (x, y, z)
//   out     | output    | out_valid / out_ready | vlr_out_t (x, y, z, flags)
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One beat per cycle unless stalled; it has two front stages (squares, sum and
// products), 24 square root stages (one root bit each), one divider prep stage,
// 16 divider stages (one quotient bit each) and the output register.
// Reset is synchronous, clears all valid bits and the mode register and sets the target to 1.0.
// Each stage holds its beat only while full and stalled, so bubbles close up.
module vector_length_rescale_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vlr_pkg::vlr_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vlr_pkg::vlr_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [vlr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [vlr_pkg::TW-1:0]     cfg_data
);
  import vlr_pkg::*;

  logic [TW-1:0] target_r;
  logic          mode_r;

  logic      f_valid, f_ready;
  vlr_item_t f_item;
  logic      s_valid, s_ready;
  vlr_root_t s_root;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_r <= cfg_data;
        REG_MODE:   mode_r   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  vlr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .target   (target_r),
    .mode     (mode_r),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_item  (f_item)
  );

  vlr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_item  (f_item),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dn_root  (s_root)
  );

  vlr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s_valid),
    .up_ready (s_ready),
    .up_root  (s_root),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

// File: rtl/vlr_checker.sv
// Port-level checker for the vector length rescale core, with its bind.
`include "assert_macros.svh"

module vlr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input vlr_pkg::vlr_out_t          out_data
);
  import vlr_pkg::*;

  // No result beat right after a reset cycle.
  `VLR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "out_valid after reset")

  // A ready sink never stalls the source side.
  `VLR_ASSERT(a_ready_through, out_ready |-> in_ready, "in_ready low with out_ready high")

  // The zero vector case gives zeros and no other flag.
  `VLR_ASSERT(a_zero_beat, out_valid && out_data.zero_length |-> !out_data.was_scaled && !out_data.saturated && out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0, "bad zero length beat")

  // Clipping only happens on a scaled beat and leaves a rail value.
  `VLR_ASSERT(a_sat_scaled, out_valid && out_data.saturated |-> out_data.was_scaled, "saturated without scaling")
  `VLR_ASSERT(a_sat_rail, out_valid && out_data.saturated |-> out_data.out_x == 16'sh7fff || out_data.out_x == -16'sh8000 || out_data.out_y == 16'sh7fff || out_data.out_y == -16'sh8000 || out_data.out_z == 16'sh7fff || out_data.out_z == -16'sh8000, "saturated without a rail value")

endmodule

bind vector_length_rescale_core vlr_checker u_vlr_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the vector length clamp and set pipeline.
`timescale 1ns / 100ps

module tb_top;
  import vlr_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  vlr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vlr_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [TW-1:0]     cfg_data = '0;

  // Mirror of the block's registers, updated with every register write.
  logic [TW-1:0] cur_target = TARGET_RESET;
  logic          cur_mode = 1'b0;

  vlr_out_t rescaled_q[$];
  int  n_errors = 0;
  int  n_beats_in = 0;
  int  n_beats_out = 0;
  int  n_scaled = 0;
  int  n_sat = 0;
  int  n_zero = 0;
  bit  idle_en = 1'b1;
  int  hold_req = 0;

  vector_length_rescale_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // One component times target over magnitude, rounded half away and saturated.
  function automatic logic signed [CW-1:0] rescale_comp(logic signed [CW-1:0] c,
      longint unsigned tgt, longint unsigned mag, ref bit sat);
    longint unsigned mag_c;
    longint unsigned quot;
    mag_c = (c < 0) ? longint'(-int'(c)) : longint'(c);
    quot = (((mag_c * tgt) << GUARD_BITS) + (mag >> 1)) / mag;
    if (c < 0) begin
      if (quot > 32768) begin
        sat = 1'b1;
        return 16'sh8000;
      end
      return CW'(-longint'(quot));
    end
    if (quot > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    return CW'(quot);
  endfunction

  // Expected result for one vector under the current register settings.
  function automatic vlr_out_t rescale_vector(vlr_in_t v);
    vlr_out_t r;
    longint unsigned sq;
    longint unsigned tgt;
    longint unsigned mag;
    bit sat;
    sq = longint'(int'(v.in_x) * int'(v.in_x)) + longint'(int'(v.in_y) * int'(v.in_y))
         + longint'(int'(v.in_z) * int'(v.in_z));
    tgt = cur_target;
    sat = 1'b0;
    r = '0;
    r.out_x = v.in_x;
    r.out_y = v.in_y;
    r.out_z = v.in_z;
    if (cur_mode) begin
      if (sq == 0) r.zero_length = 1'b1;
      else r.was_scaled = 1'b1;
    end else if (sq > tgt * tgt) begin
      r.was_scaled = 1'b1;
    end
    if (r.was_scaled) begin
      mag = int_sqrt(sq << (2 * GUARD_BITS));
      r.out_x = rescale_comp(v.in_x, tgt, mag, sat);
      r.out_y = rescale_comp(v.in_y, tgt, mag, sat);
      r.out_z = rescale_comp(v.in_z, tgt, mag, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  // Wait until every expected beat has come out, then let the pipe settle.
  task automatic drain_pipe();
    while (rescaled_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Register write; only called while the pipe is empty.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [TW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TARGET) cur_target = data;
    else if (idx == REG_MODE) cur_mode = data[0];
    @(posedge clk);
  endtask

  // Offer one vector, after a random gap if idle_en is set, and log its expected result.
  task automatic send_vector(vlr_in_t v);
    vlr_out_t r;
    while (idle_en && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
    r = rescale_vector(v);
    rescaled_q.push_back(r);
    n_beats_in++;
    if (r.was_scaled) n_scaled++;
    if (r.saturated) n_sat++;
    if (r.zero_length) n_zero++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random vector: mostly moderate sizes, some full range, near-target and zeros.
  function automatic vlr_in_t rand_vector();
    vlr_in_t v;
    int sh;
    int pick;
    pick = $urandom_range(99);
    sh = $urandom_range(15);
    v.in_x = CW'($urandom) >>> sh;
    v.in_y = CW'($urandom) >>> sh;
    v.in_z = CW'($urandom) >>> sh;
    if (pick < 30) begin
      v.in_x = CW'($urandom);
      v.in_y = CW'($urandom);
      v.in_z = CW'($urandom);
    end else if (pick < 38) begin
      v = '0;
      v.in_x = cur_target[CW-1] ? 16'sh7fff : CW'(cur_target);
      if ($urandom_range(1)) v.in_x = -v.in_x;
      v.in_y = CW'($urandom_range(2)) - 16'd1;
    end else if (pick < 42) begin
      v = '0;
    end
    return v;
  endfunction

  // Receiver: random stalls, stall-free stretches and requested long holds.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      out_ready <= !idle_en || ($urandom_range(99) >= 24);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    vlr_out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_beats_out++;
      if (rescaled_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        n_errors++;
      end else begin
        e = rescaled_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, out_data.out_x);
          n_errors++;
        end
        if (out_data.out_y !== e.out_y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, out_data.out_y);
          n_errors++;
        end
        if (out_data.out_z !== e.out_z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, e.out_z, out_data.out_z);
          n_errors++;
        end
        if (out_data.was_scaled !== e.was_scaled) begin
          $display("%0t: was_scaled expected %b actual %b", $time, e.was_scaled,
                   out_data.was_scaled);
          n_errors++;
        end
        if (out_data.zero_length !== e.zero_length) begin
          $display("%0t: zero_length expected %b actual %b", $time, e.zero_length,
                   out_data.zero_length);
          n_errors++;
        end
        if (out_data.saturated !== e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                   out_data.saturated);
          n_errors++;
        end
      end
    end
  end

  // Directed rows: register settings, vector, and a hand-read result where obvious.
  typedef struct {
    logic [TW-1:0] target;
    logic          mode;
    vlr_in_t       vec;
    bit            known;
    vlr_out_t      res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // Reset settings: unit vector passes, length equal to target.
    '{16'd256, 1'b0, '{16'sd256, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd256, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
    // Zero vector in clamp mode passes with no flags.
    '{16'd256, 1'b0, '{16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
    // Most negative component clamps to unit length.
    '{16'd256, 1'b0, '{-16'sd32768, 16'sd0, 16'sd0}, 1'b1,
      '{-16'sd256, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
    '{16'd256, 1'b0, '{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{16'd256, 1'b0, '{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
    '{16'd256, 1'b0, '{16'sd100, -16'sd100, 16'sd50}, 1'b0, '0},
    // Zero target: a longer vector becomes zeros with the scaled flag.
    '{16'd0, 1'b0, '{16'sd256, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
    '{16'd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
    // Set mode normalises.
    '{16'd256, 1'b1, '{16'sd512, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd256, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
    '{16'd256, 1'b1, '{16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0}},
    '{16'd256, 1'b1, '{16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
    '{16'd256, 1'b1, '{16'sd32767, -16'sd32768, 16'sd1}, 1'b0, '0},
    // Largest target in set mode saturates.
    '{16'd65535, 1'b1, '{16'sd1, 16'sd0, 16'sd0}, 1'b1,
      '{16'sh7fff, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1}},
    '{16'd65535, 1'b1, '{-16'sd1, 16'sd0, 16'sd0}, 1'b1,
      '{-16'sd32768, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1}},
    '{16'd65535, 1'b1, '{16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0}},
    '{16'd65535, 1'b1, '{16'sd300, 16'sd400, -16'sd500}, 1'b0, '0},
    '{16'd65535, 1'b0, '{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{16'd65535, 1'b0, '{-16'sd32768, 16'sd0, 16'sd0}, 1'b0, '0},
    '{16'd1, 1'b0, '{16'sd1, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
    '{16'd1, 1'b0, '{16'sd1, 16'sd1, 16'sd0}, 1'b0, '0},
    '{16'd1, 1'b1, '{16'sd12345, -16'sd2345, 16'sd345}, 1'b0, '0}
  };

  // Stimulus: directed table, then random phases over several settings.
  initial begin
    vlr_out_t r;
    logic [TW-1:0] tgt;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Writes to indexes beyond the register list must leave both registers alone.
    write_reg(2'd2, 16'hffff);
    write_reg(2'd3, 16'hffff);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].target != cur_target || dir_rows[i].mode != cur_mode) begin
        end_burst();
        drain_pipe();
        write_reg(REG_TARGET, dir_rows[i].target);
        write_reg(REG_MODE, {{(TW-1){1'b0}}, dir_rows[i].mode});
      end
      if (dir_rows[i].known) begin
        r = rescale_vector(dir_rows[i].vec);
        if (r !== dir_rows[i].res) begin
          $display("%0t: directed row %0d expected %h predicted %h", $time, i,
                   dir_rows[i].res, r);
          n_errors++;
        end
      end
      send_vector(dir_rows[i].vec);
    end
    end_burst();
    drain_pipe();

    for (phase = 0; phase < 13; phase++) begin
      case (phase % 6)
        0: tgt = 16'd256;
        1: tgt = 16'd0;
        2: tgt = 16'd65535;
        3: tgt = 16'd1;
        default: tgt = TW'($urandom);
      endcase
      write_reg(REG_TARGET, tgt);
      write_reg(REG_MODE, TW'(phase % 2));
      idle_en = (phase != 4);
      if (phase == 7) hold_req = 300;
      repeat (100) send_vector(rand_vector());
      // Sender waits for every result before the next setting.
      end_burst();
      drain_pipe();
    end
    idle_en = 1'b1;

    $display("Covered %0d vectors in, %0d results out: %0d scaled, %0d saturated, %0d zero.",
             n_beats_in, n_beats_out, n_scaled, n_sat, n_zero);
    $display("Settings swept targets 0, 1, 1.0, max and random in clamp and set modes.");
    if (n_errors == 0 && rescaled_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vlr_pkg.sv
rtl/vlr_front.sv
rtl/vlr_sqrt.sv
rtl/vlr_div.sv
rtl/vector_length_rescale_core.sv
rtl/vlr_checker.sv
dv/tb_top.sv
